// ===== design/capped_cost_path_search_unit_assert.svh =====
// Assertion macros for the capped-cost path search unit.
`ifndef CAPPED_COST_PATH_SEARCH_UNIT_ASSERT_SVH
`define CAPPED_COST_PATH_SEARCH_UNIT_ASSERT_SVH
// Antecedent implies consequent in the same cycle.
`define CCPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define CCPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/ccps_pkg.sv =====
// Shared types and codes of the capped-cost path search unit.
package ccps_pkg;
    localparam int VTX_W        = 4;
    localparam int COST_W       = 32;
    localparam int NUM_VERTICES = 16;
    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_PATH  = 2'd2,
        ST_NONE  = 2'd3
    } t_status;
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
endpackage

// ===== design/ccps_edge_store.sv =====
// Edge store memory: one write port, one registered read port.
module ccps_edge_store #(
    parameter int MAX_EDGES = 64,
    parameter int EW        = 6
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [EW-1:0]                 i_waddr,
    input  logic [ccps_pkg::VTX_W-1:0]    i_wfrom,
    input  logic [ccps_pkg::VTX_W-1:0]    i_wto,
    input  logic signed [ccps_pkg::COST_W-1:0] i_wcost,
    input  logic [EW-1:0]                 i_raddr,
    output logic [ccps_pkg::VTX_W-1:0]    o_rfrom,
    output logic [ccps_pkg::VTX_W-1:0]    o_rto,
    output logic signed [ccps_pkg::COST_W-1:0] o_rcost
);
    import ccps_pkg::*;
    localparam int DW = 2*VTX_W + COST_W;
    logic [DW-1:0] mem [MAX_EDGES];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wfrom, i_wto, i_wcost};
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rfrom = r_rdata[DW-1 -: VTX_W];
    assign o_rto   = r_rdata[COST_W +: VTX_W];
    assign o_rcost = r_rdata[COST_W-1:0];
endmodule

// ===== design/capped_cost_path_search_unit.sv =====
// Capped-cost path search unit: edge list store and depth-first path query.
//
// A request is taken when i_start is high and o_busy is low. An add request
// (action 0) stores an undirected edge and answers one result in the next
// cycle: added, or store full. A query request (action 1) runs a depth-first
// search with backtracking from first_vertex to second_vertex over edges whose
// signed cost is at most max_cost, trying neighbors in insertion order. It
// answers the path vertices start to destination, one per cycle, last set on
// the destination, or a single not-possible result. Results appear for one
// cycle under o_valid; the receiver cannot stall them. Edges sit in a memory
// with a registered read port; the search scans it one edge per cycle, passing
// through the issue state whenever it descends or backtracks. The DFS stack
// (vertex and resume position per level) is small and held in registers;
// visited marks are flip-flops cleared at each query start.
module capped_cost_path_search_unit #(
    parameter int MAX_EDGES    = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic                               i_action,
    input  logic [ccps_pkg::VTX_W-1:0]         i_first_vertex,
    input  logic [ccps_pkg::VTX_W-1:0]         i_second_vertex,
    input  logic signed [ccps_pkg::COST_W-1:0] i_edge_cost,
    input  logic signed [ccps_pkg::COST_W-1:0] i_max_cost,
    output logic                               o_valid,
    output logic [1:0]                         o_status,
    output logic [ccps_pkg::VTX_W-1:0]         o_vertex,
    output logic                               o_last
);
    import ccps_pkg::*;

    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int SW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int DW = $clog2(NUM_VERTICES + 1);
    localparam int PW = $clog2(MAX_EDGES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_SCAN, S_EMIT, S_DONE
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_count;
    logic [VTX_W-1:0] r_dest;
    logic signed [COST_W-1:0] r_limit;
    logic [NUM_VERTICES-1:0] r_seen;
    logic [VTX_W-1:0] r_stk_v [NUM_VERTICES];
    logic [PW-1:0]    r_stk_e [NUM_VERTICES];
    logic [DW-1:0] r_depth;
    logic [PW-1:0] r_pos;      // edge whose read data arrives this cycle
    logic [DW-1:0] r_emit;
    logic r_valid, r_last;
    logic [1:0] r_status;
    logic [VTX_W-1:0] r_vertex;

    logic [EW-1:0] raddr;
    logic [VTX_W-1:0] rd_from, rd_to, other;
    logic signed [COST_W-1:0] rd_cost;
    logic [SW-1:0] top;
    logic [VTX_W-1:0] cur_v;
    logic hit_from, hit_to, usable;
    logic add_we;

    assign add_we = (r_state == S_IDLE) && i_start && (i_action == ACT_ADD)
                    && (r_count < CW'(MAX_EDGES));

    ccps_edge_store #(.MAX_EDGES(MAX_EDGES), .EW(EW)) u_store (
        .i_clk  (i_clk),
        .i_we   (add_we),
        .i_waddr(r_count[EW-1:0]),
        .i_wfrom(i_first_vertex),
        .i_wto  (i_second_vertex),
        .i_wcost(i_edge_cost),
        .i_raddr(raddr),
        .o_rfrom(rd_from),
        .o_rto  (rd_to),
        .o_rcost(rd_cost)
    );

    assign top   = SW'(r_depth - DW'(1));
    assign cur_v = r_stk_v[top];
    assign hit_from = (rd_from == cur_v);
    assign hit_to   = (rd_to == cur_v);
    assign other    = hit_from ? rd_to : rd_from;
    assign usable = (hit_from || hit_to) && ({2'b0, other} < (VTX_W+2)'(NUM_VERTICES))
                    && !r_seen[other[SW-1:0]] && (rd_cost <= r_limit);

    // Read address: in scan, prefetch the next edge; on ISSUE, the resume point.
    always_comb begin
        if (r_state == S_SCAN) begin
            raddr = EW'(r_pos + PW'(1));
        end else begin
            raddr = EW'(r_stk_e[top]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_valid <= 1'b0;
        r_last  <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_depth <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // stack depth is already zero here
                    if (i_start) begin
                        if (i_action == ACT_ADD) begin
                            r_valid  <= 1'b1;
                            r_last   <= 1'b1;
                            r_vertex <= '0;
                            if (r_count < CW'(MAX_EDGES)) begin
                                r_status <= ST_ADDED;
                                r_count  <= r_count + CW'(1);
                            end else begin
                                r_status <= ST_FULL;
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_seen  <= '0;
                            r_dest  <= i_second_vertex;
                            r_limit <= i_max_cost;
                            r_emit  <= '0;
                            if ({1'b0, i_first_vertex} >= (VTX_W+1)'(NUM_VERTICES) ||
                                {1'b0, i_second_vertex} >= (VTX_W+1)'(NUM_VERTICES)) begin
                                r_valid  <= 1'b1;
                                r_last   <= 1'b1;
                                r_status <= ST_NONE;
                                r_vertex <= '0;
                                r_state  <= S_DONE;
                            end else if (i_first_vertex == i_second_vertex) begin
                                r_state <= S_EMIT;
                            end else begin
                                r_seen[i_first_vertex[SW-1:0]] <= 1'b1;
                                r_stk_v[0] <= i_first_vertex;
                                r_stk_e[0] <= '0;
                                r_depth <= DW'(1);
                                r_state <= S_ISSUE;
                            end
                        end
                    end
                end
                S_ISSUE: begin
                    if (r_depth == '0) begin
                        r_valid  <= 1'b1;
                        r_last   <= 1'b1;
                        r_status <= ST_NONE;
                        r_vertex <= '0;
                        r_state  <= S_DONE;
                    end else if (r_stk_e[top] >= PW'(r_count)) begin
                        r_depth <= r_depth - DW'(1);   // exhausted: backtrack
                    end else begin
                        r_pos   <= r_stk_e[top];
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (usable) begin
                        r_stk_e[top] <= r_pos + PW'(1);
                        if (other == r_dest) begin
                            r_emit  <= '0;
                            r_state <= S_EMIT;
                        end else if (r_depth < DW'(NUM_VERTICES)) begin
                            r_seen[other[SW-1:0]] <= 1'b1;
                            r_stk_v[r_depth[SW-1:0]] <= other;
                            r_stk_e[r_depth[SW-1:0]] <= '0;
                            r_depth <= r_depth + DW'(1);
                            r_state <= S_ISSUE;
                        end else if (r_pos + PW'(1) >= PW'(r_count)) begin
                            r_depth <= r_depth - DW'(1);
                            r_state <= S_ISSUE;
                        end else begin
                            r_pos <= r_pos + PW'(1);
                        end
                    end else if (r_pos + PW'(1) >= PW'(r_count)) begin
                        r_depth <= r_depth - DW'(1);
                        r_state <= S_ISSUE;
                    end else begin
                        r_pos <= r_pos + PW'(1);
                    end
                end
                S_EMIT: begin
                    r_valid  <= 1'b1;
                    r_status <= ST_PATH;
                    if (r_emit < r_depth) begin
                        r_vertex <= r_stk_v[r_emit[SW-1:0]];
                        r_emit   <= r_emit + DW'(1);
                    end else begin
                        r_vertex <= r_dest;
                        r_last   <= 1'b1;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_depth <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_vertex = r_vertex;
    assign o_last   = r_last;
endmodule

// ===== design/ccps_checker.sv =====
// Port-level checker for the capped-cost path search unit, with bind.
`include "capped_cost_path_search_unit_assert.svh"
module ccps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_valid,
    input logic [1:0] o_status,
    input logic [3:0] o_vertex,
    input logic       o_last
);
    import ccps_pkg::*;
    // Accepting a request makes the unit busy next cycle.
    `CCPS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // Add and not-possible answers are single results.
    `CCPS_ASSERT_IMP(a_single, i_clk, i_rst_n, o_valid && o_status != ST_PATH, o_last)
    // Non-path results carry vertex zero.
    `CCPS_ASSERT_IMP(a_vzero, i_clk, i_rst_n, o_valid && o_status != ST_PATH, o_vertex == 4'd0)
    // While a final result is shown, the unit is still busy.
    `CCPS_ASSERT_IMP(a_last_busy, i_clk, i_rst_n, o_valid && o_last, o_busy)
endmodule

bind capped_cost_path_search_unit ccps_checker u_ccps_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_valid(o_valid), .o_status(o_status), .o_vertex(o_vertex), .o_last(o_last)
);
